[hdl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define SBL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds through reset
`define SBL_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/sbl_pkg.sv]
// types and constants shared by the stack blur line filter
// no dependencies
package sbl_pkg;

  // channel and pixel layout
  localparam int CH_W   = 8;
  localparam int NUM_CH = 4;

  // configuration port and register widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int RADIUS_W   = 6;
  localparam int MUL_W      = 10;
  localparam int SHIFT_W    = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_MUL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_SHIFT = 2'd2;

  // register reset values
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd1;
  localparam logic [MUL_W-1:0]    MUL_RST    = 10'd512;
  localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 5'd11;

  // channel 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_WAIT,
    ST_LOAD
  } seq_state_t;

  // per-tap control handed to the channel lanes
  typedef struct packed {
    logic term;
    logic first;
    logic last;
  } lane_ctl_t;

endpackage

[hdl/sbl_pix_if.sv]
// pixel request channel: valid/ready plus one premultiplied RGBA8 pixel
// depends on sbl_pkg
interface sbl_pix_if;
  import sbl_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;
  logic [CH_W-1:0] in_alpha;
  logic            line_end;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, line_end,
                  input ready);
  modport sink (input valid, in_red, in_green, in_blue, in_alpha, line_end,
                output ready);
endinterface

[hdl/sbl_res_if.sv]
// result request channel: valid/ready plus one blurred pixel and last flag
// depends on sbl_pkg
interface sbl_res_if;
  import sbl_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;
  logic            out_last;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, out_last,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, out_last,
                output ready);
endinterface

[hdl/sbl_lane.sv]
// one channel lane: weighted tap accumulation, normalize multiply, shift and clip
// depends on sbl_pkg
module sbl_lane #(
  parameter int WGT_W = 7,
  parameter int ACC_W = 22
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sbl_pkg::lane_ctl_t         ctl,
  input  logic [WGT_W-1:0]           weight,
  input  logic [sbl_pkg::CH_W-1:0]   px,
  input  logic [sbl_pkg::MUL_W-1:0]  mul,
  input  logic [sbl_pkg::SHIFT_W-1:0] shift,
  output logic [sbl_pkg::CH_W-1:0]   res,
  output logic                       res_valid
);
  import sbl_pkg::*;

  localparam int TERM_W = WGT_W + CH_W;
  localparam int PROD_W = ACC_W + MUL_W;

  logic [TERM_W-1:0] term_p;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_next;
  logic [PROD_W-1:0] shifted;
  logic [CH_W-1:0]   res_next;
  logic              sum_done;
  logic              norm_done;

  // weighted tap, restarting the sum on the first tap of a window
  assign term_p   = weight * px;
  assign acc_next = (ctl.first ? '0 : acc) + ACC_W'(term_p);

  // normalize and clip to the channel range
  assign prod_next = acc * mul;
  assign shifted   = prod >> shift;
  assign res_next  = (|shifted[PROD_W-1:CH_W]) ? '1 : shifted[CH_W-1:0];

  // stage strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_done  <= 1'b0;
      norm_done <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      sum_done  <= ctl.term & ctl.last;
      norm_done <= sum_done;
      res_valid <= norm_done;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctl.term) begin
      acc <= acc_next;
    end
    if (sum_done) begin
      prod <= prod_next;
    end
    if (norm_done) begin
      res <= res_next;
    end
  end
endmodule

[hdl/sbl_out.sv]
// output stage: merges the four lane results and the last flag into the
// result register that faces the result channel; depends on sbl_pkg, sbl_res_if
module sbl_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sbl_pkg::pixel_t  px,
  input  logic             last,
  output logic             free,
  sbl_res_if.source        res
);
  import sbl_pkg::*;

  logic   valid;
  pixel_t data;
  logic   data_last;

  // register can take a new result when empty or being drained this cycle
  assign free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data      <= px;
      data_last <= last;
    end
  end

  assign res.valid     = valid;
  assign res.out_red   = data[0];
  assign res.out_green = data[1];
  assign res.out_blue  = data[2];
  assign res.out_alpha = data[3];
  assign res.out_last  = data_last;
endmodule

[hdl/stack_blur_line_filter_top.sv]
// Stack blur, horizontal pass, over a stream of premultiplied RGBA8 pixels.
// Each output is the triangle-weighted sum over 2r+1 neighbours (edge pixels
// repeated), times norm_multiplier, shifted right by norm_shift, clipped to 255.
// Pixel x+r yields output x; the pixel flagged line_end yields all outputs
// still open, the final one with out_last. Registers are taken up at the first
// pixel of a line. A pixel that yields no output does not hold off the next one;
// one that yields outputs holds off the next pixel until the last is loaded,
// because the pixel ring memory gives one tap per cycle through its single read
// port to the four channel lanes, which then normalize through their product
// and result registers before the result is loaded. The result register lets
// the next pixel in while a result waits. The ring needs no clearing after reset.
module stack_blur_line_filter_top #(
  parameter int MAX_RADIUS = 63
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbl_pkg::CFG_DATA_W-1:0] cfg_data,
  sbl_pix_if.sink                       pix,
  sbl_res_if.source                     res
);
  import sbl_pkg::*;

  localparam int RING_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int WGT_W      = $clog2(MAX_RADIUS + 2);
  localparam int ACC_W      = CH_W + 2 * WGT_W;
  localparam int CMP_W      = (RAD_W > RADIUS_W) ? RAD_W : RADIUS_W;

  // configuration registers
  logic [RADIUS_W-1:0] radius;
  logic [MUL_W-1:0]    norm_multiplier;
  logic [SHIFT_W-1:0]  norm_shift;

  // per-line settings
  logic [RAD_W-1:0]   line_r;
  logic [MUL_W-1:0]   line_mul;
  logic [SHIFT_W-1:0] line_shift;

  // ring and line position
  pixel_t             ring [RING_DEPTH];
  pixel_t             pix_px;
  pixel_t             rd_data;
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   newest;
  logic [CNT_W-1:0]   seen;
  logic [CNT_W-1:0]   seen_new;
  logic [PTR_W-1:0]   seen_m1;
  logic [PTR_W-1:0]   last_idx;

  // sequencer
  seq_state_t         state;
  seq_state_t         state_next;
  logic [RAD_W-1:0]   dc;
  logic               line_done;
  logic [PTR_W-1:0]   j;
  logic [PTR_W-1:0]   last_j;
  logic               acc_in;
  logic               issue;
  logic               load;
  logic               out_free;
  logic               res_done;

  // accept-time decisions
  logic [CMP_W-1:0]   radius_ext;
  logic [RAD_W-1:0]   r_clamp;
  logic [RAD_W-1:0]   r_cur;
  logic               emit_mid;
  logic               has_out;
  logic [RAD_W-1:0]   first_dc;

  // tap addressing
  logic [PTR_W-1:0]   base;
  logic [PTR_W-1:0]   dist_raw;
  logic [PTR_W-1:0]   tap_dist;
  logic [PTR_W:0]     wrap;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W:0]     weight_wide;
  logic [WGT_W-1:0]   weight;
  logic [WGT_W-1:0]   w1;
  lane_ctl_t          ctl1;

  // lane results
  pixel_t             lane_res;
  logic [NUM_CH-1:0]  lane_done;

  assign pix_px = {pix.in_alpha, pix.in_blue, pix.in_green, pix.in_red};
  assign acc_in = pix.valid && pix.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radius          <= RADIUS_RST;
      norm_multiplier <= MUL_RST;
      norm_shift      <= SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS:     radius          <= cfg_data[RADIUS_W-1:0];
        REG_NORM_MUL:   norm_multiplier <= cfg_data[MUL_W-1:0];
        REG_NORM_SHIFT: norm_shift      <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // radius for this pixel: taken from the register at the first pixel of a line
  assign radius_ext = CMP_W'(radius);
  assign r_clamp    = (radius_ext > CMP_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                        : RAD_W'(radius_ext);
  assign r_cur      = (seen == '0) ? r_clamp : line_r;

  // saturating pixel count and output decision
  assign seen_new = (seen == CNT_W'(RING_DEPTH)) ? seen : CNT_W'(seen + 1'b1);
  assign seen_m1  = PTR_W'(seen_new - 1'b1);
  assign emit_mid = seen_m1 >= PTR_W'(r_cur);
  assign has_out  = pix.line_end || emit_mid;
  assign first_dc = (seen_m1 < PTR_W'(r_cur)) ? RAD_W'(seen_m1) : r_cur;

  // line and window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      seen       <= '0;
      line_r     <= '0;
      line_mul   <= '0;
      line_shift <= '0;
      newest     <= '0;
      last_idx   <= '0;
      dc         <= '0;
      line_done  <= 1'b0;
    end else if (acc_in) begin
      newest    <= wr_ptr;
      wr_ptr    <= (wr_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      seen      <= pix.line_end ? '0 : seen_new;
      last_idx  <= seen_m1;
      dc        <= pix.line_end ? first_dc : r_cur;
      line_done <= pix.line_end;
      if (seen == '0) begin
        line_r     <= r_clamp;
        line_mul   <= norm_multiplier;
        line_shift <= norm_shift;
      end
    end else if (load && state_next == ST_ACC) begin
      dc <= dc - 1'b1;
    end
  end

  // tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else if (state == ST_ACC) begin
      j <= PTR_W'(j + 1'b1);
    end else begin
      j <= '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (acc_in && has_out) state_next = ST_ACC;
      ST_ACC:  if (j == last_j) state_next = ST_WAIT;
      ST_WAIT: if (res_done) state_next = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          state_next = (line_done && dc != '0) ? ST_ACC : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer outputs
  always_comb begin
    pix.ready = 1'b0;
    issue     = 1'b0;
    load      = 1'b0;
    case (state)
      ST_IDLE: pix.ready = 1'b1;
      ST_ACC:  issue     = 1'b1;
      ST_WAIT: ;
      ST_LOAD: load      = out_free;
      default: ;
    endcase
  end

  // tap address: clamp the distance from the newest pixel to the line
  assign last_j   = PTR_W'({line_r, 1'b0});
  assign base     = PTR_W'(dc) + PTR_W'(line_r);
  assign dist_raw = (j > base) ? '0 : PTR_W'(base - j);
  assign tap_dist = (dist_raw > last_idx) ? last_idx : dist_raw;
  assign wrap     = {1'b0, newest} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, tap_dist};
  assign rd_addr  = (newest >= tap_dist) ? PTR_W'(newest - tap_dist) : wrap[PTR_W-1:0];

  // triangle weight r+1-|k| for tap k = j-r
  assign weight_wide = (j <= PTR_W'(line_r)) ? {1'b0, j} + 1'b1
                                             : {1'b0, last_j} + 1'b1 - {1'b0, j};
  assign weight      = WGT_W'(weight_wide);

  // pixel ring memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (acc_in) begin
      ring[wr_ptr] <= pix_px;
    end
    rd_data <= ring[rd_addr];
  end

  // tap control aligned with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1.term  <= issue;
      ctl1.first <= issue && (j == '0);
      ctl1.last  <= issue && (j == last_j);
    end
  end

  always_ff @(posedge clk) begin
    w1 <= weight;
  end

  // one lane per channel
  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    sbl_lane #(
      .WGT_W(WGT_W),
      .ACC_W(ACC_W)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl1),
      .weight   (w1),
      .px       (rd_data[g]),
      .mul      (line_mul),
      .shift    (line_shift),
      .res      (lane_res[g]),
      .res_valid(lane_done[g])
    );
  end

  assign res_done = &lane_done;

  // merge lane results into the result register
  sbl_out u_out (
    .clk (clk),
    .rst (rst),
    .load(load),
    .px  (lane_res),
    .last(line_done && dc == '0),
    .free(out_free),
    .res (res)
  );
endmodule

[hdl/sbl_checker.sv]
// port-level checks for the stack blur line filter, bound to the top level
// depends on sbl_pkg and assert_macros.svh
`include "assert_macros.svh"

module sbl_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     pix_valid,
  input logic                     pix_ready,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic [sbl_pkg::CH_W-1:0] res_red,
  input logic [sbl_pkg::CH_W-1:0] res_green,
  input logic [sbl_pkg::CH_W-1:0] res_blue,
  input logic [sbl_pkg::CH_W-1:0] res_alpha,
  input logic                     res_last
);
  import sbl_pkg::*;

  // a stalled result request stays up
  `SBL_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid, "result dropped while stalled")

  // a stalled result request keeps its payload
  `SBL_ASSERT(a_res_stable, clk, rst, res_valid && !res_ready |=> $stable(res_red) && $stable(res_green) && $stable(res_blue) && $stable(res_alpha) && $stable(res_last), "result payload changed while stalled")

  // out of reset the block is empty and takes pixels
  `SBL_ASSERT_NORST(a_reset_idle, clk, rst |=> pix_ready && !res_valid, "not idle after reset")

  // a taken pixel does not make a result appear right away
  `SBL_ASSERT(a_no_instant_result, clk, rst, pix_valid && pix_ready |=> !$rose(res_valid), "result appeared right after a pixel")
endmodule

bind stack_blur_line_filter_top sbl_checker u_sbl_checker (
  .clk      (clk),
  .rst      (rst),
  .pix_valid(pix.valid),
  .pix_ready(pix.ready),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_red  (res.out_red),
  .res_green(res.out_green),
  .res_blue (res.out_blue),
  .res_alpha(res.out_alpha),
  .res_last (res.out_last)
);
